[rtl/core/dci_pkg.sv]
// Package: shared types, constants and helpers of the distance constraint impulse block.
`default_nettype none

package dci_pkg;

   // pipeline geometry
   localparam int SQ_STEPS    = 26;
   localparam int DIV_STEPS   = 34;
   localparam int DIV_LANES_A = 3;
   localparam int DIV_LANES_B = 6;
   localparam int PRE_STAGES  = 3;
   localparam int MID_STAGES  = 4;
   localparam int PIPE_DEPTH  = PRE_STAGES + SQ_STEPS + DIV_STEPS + MID_STAGES + DIV_STEPS;

   // divider lane widths
   localparam int DEN_W = 33;
   localparam int REM_W = 33;
   localparam int NUM_W = 64;
   localparam int QUO_W = 34;

   // square root lane widths
   localparam int RAD_W   = 52;
   localparam int ROOT_W  = 26;
   localparam int SQREM_W = 27;

   localparam int CSR_IDX_W = 3;

   // gap limit 1000.0 in Q16.16, and its square in Q32.32
   localparam logic signed [33:0] D_LIMIT  = 34'sd65536000;
   localparam logic [54:0]        LIMIT_SQ = 55'd65536000 * 55'd65536000;

   // floor(x / 5) = (x * RECIP5) >> RECIP5_SHIFT for x below 2^32
   localparam logic [31:0] RECIP5       = 32'hCCCC_CCCD;
   localparam int          RECIP5_SHIFT = 34;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_X,
      CSR_OFFSET_Y,
      CSR_OFFSET_Z,
      CSR_TARGET,
      CSR_INV_MASS_A,
      CSR_INV_MASS_B
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] pos_a_x;
      logic signed [31:0] pos_a_y;
      logic signed [31:0] pos_a_z;
      logic signed [31:0] pos_b_x;
      logic signed [31:0] pos_b_y;
      logic signed [31:0] pos_b_z;
      logic signed [31:0] vel_a_x;
      logic signed [31:0] vel_a_y;
      logic signed [31:0] vel_a_z;
      logic signed [31:0] vel_b_x;
      logic signed [31:0] vel_b_y;
      logic signed [31:0] vel_b_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_vel_a_x;
      logic signed [31:0] new_vel_a_y;
      logic signed [31:0] new_vel_a_z;
      logic signed [31:0] new_vel_b_x;
      logic signed [31:0] new_vel_b_y;
      logic signed [31:0] new_vel_b_z;
      logic               applied;
   } rsp_type;

   // one restoring division lane: partial remainder, numerator bits still to
   // shift in (msb first), quotient so far, divisor
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [NUM_W-1:0] num;
      logic [QUO_W-1:0] quo;
      logic [DEN_W-1:0] den;
   } div_lane_type;

   // one digit-by-digit square root lane
   typedef struct packed {
      logic [SQREM_W-1:0] rem;
      logic [RAD_W-1:0]   rad;
      logic [ROOT_W-1:0]  root;
   } sqrt_lane_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -36'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/core/distance_constraint_impulse.sv]
// Top level: distance joint impulse with Baumgarte bias, one item per cycle unless stalled.
//
//  channel | ports                          | dir | transfer when
//  --------+--------------------------------+-----+------------------------------
//  req     | req_valid req_stall req_data   | in  | req_valid && !req_stall
//  rsp     | rsp_valid rsp_stall rsp_data   | out | rsp_valid && !rsp_stall
//  csr     | csr_valid csr_ready csr_index  | in  | csr_valid && csr_ready
//          | csr_data                       |     |
//
// Throughput is one item per cycle while req_stall is low. A req transfer
// reaches rsp_valid through stages 1..3, the 26-cell square root chain and two
// 34-cell divider chains (relative speed and impulse shares, then the per-axis
// impulse) with stages 5..8 between them, and the output register.
// Reset clears the valid bits, the output and skid flags and the csr registers.
// A stalled result sits in the output register while the pipe keeps moving; one
// more result lands in the skid register, and only then req_stall rises.
`default_nettype none

module distance_constraint_impulse (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire dci_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output dci_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [dci_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [31:0]                       csr_data
);

   // state carried alongside the arithmetic chains
   typedef struct packed {
      logic             ok;
      logic [25:0]      gap_len;
      logic [2:0][25:0] dmag;
      logic [2:0]       dneg;
      logic [2:0][31:0] va;
      logic [2:0][31:0] vb;
   } carry_type;

   typedef struct packed {
      logic             ok;
      logic [2:0][26:0] d;
      logic [2:0][32:0] dv;
      logic [2:0][31:0] va;
      logic [2:0][31:0] vb;
   } st1_type;

   typedef struct packed {
      logic             ok;
      logic [2:0][26:0] d;
      logic [2:0][52:0] sq;
      logic [2:0][59:0] dp;
      logic [2:0][31:0] va;
      logic [2:0][31:0] vb;
   } st2_type;

   typedef struct packed {
      carry_type   c;
      logic [54:0] sumsq;
      logic [61:0] dot;
   } st3_type;

   typedef struct packed {
      carry_type   c;
      logic [59:0] dot_mag;
      logic        dot_neg;
   } sq_side_type;

   typedef struct packed {
      carry_type   c;
      logic        dot_neg;
      logic        bias_neg;
      logic [25:0] bias;
   } a_side_type;

   typedef struct packed {
      carry_type   c;
      logic [35:0] s;
      logic [30:0] ra;
      logic [30:0] rb;
   } st5_type;

   typedef struct packed {
      carry_type   c;
      logic        sneg;
      logic [33:0] smag;
      logic [30:0] ra;
      logic [30:0] rb;
   } st6_type;

   typedef struct packed {
      carry_type   c;
      logic        sneg;
      logic [33:0] ka;
      logic [33:0] kb;
   } st7_type;

   typedef struct packed {
      carry_type        c;
      logic [5:0][59:0] prod;
      logic [5:0]       neg;
   } st8_type;

   typedef struct packed {
      carry_type  c;
      logic [5:0] neg;
   } b_side_type;

   // ---------------------------------------------------------------- csr
   logic signed [31:0] off_ff [3];
   logic [25:0]        target_ff;
   logic [31:0]        inv_a_ff;
   logic [31:0]        inv_b_ff;
   logic [32:0]        total_ff;
   logic               csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff[0] <= '0;
         off_ff[1] <= '0;
         off_ff[2] <= '0;
         target_ff <= '0;
         inv_a_ff  <= '0;
         inv_b_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            dci_pkg::CSR_OFFSET_X:   off_ff[0] <= csr_data;
            dci_pkg::CSR_OFFSET_Y:   off_ff[1] <= csr_data;
            dci_pkg::CSR_OFFSET_Z:   off_ff[2] <= csr_data;
            dci_pkg::CSR_TARGET:     target_ff <= csr_data[25:0];
            dci_pkg::CSR_INV_MASS_A: inv_a_ff  <= csr_data;
            dci_pkg::CSR_INV_MASS_B: inv_b_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // total inverse mass, registered from the two inverse mass registers; items need
   // far longer to reach its first reader
   always_ff @(posedge clock) begin
      total_ff <= {1'b0, inv_a_ff} + {1'b0, inv_b_ff};
   end

   // ---------------------------------------------------------------- flow control
   logic [dci_pkg::PIPE_DEPTH-1:0] vld_ff;
   logic                           en;
   logic                           out_vld_ff;
   logic                           skid_vld_ff;
   dci_pkg::rsp_type               out_ff;
   dci_pkg::rsp_type               skid_ff;
   dci_pkg::rsp_type               tail_rsp;
   logic                           take;
   logic                           tail_vld;

   assign en        = !skid_vld_ff;
   assign req_stall = skid_vld_ff;
   assign take      = out_vld_ff && !rsp_stall;
   assign tail_vld  = vld_ff[dci_pkg::PIPE_DEPTH-1];
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[dci_pkg::PIPE_DEPTH-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------------- stage 1: gap
   logic signed [31:0] pa [3];
   logic signed [31:0] pb [3];
   logic signed [31:0] va [3];
   logic signed [31:0] vb [3];
   logic signed [33:0] dfull [3];
   logic signed [32:0] dvel [3];
   st1_type            st1_in;
   st1_type            st1_ff;

   assign pa[0] = req_data.pos_a_x;
   assign pa[1] = req_data.pos_a_y;
   assign pa[2] = req_data.pos_a_z;
   assign pb[0] = req_data.pos_b_x;
   assign pb[1] = req_data.pos_b_y;
   assign pb[2] = req_data.pos_b_z;
   assign va[0] = req_data.vel_a_x;
   assign va[1] = req_data.vel_a_y;
   assign va[2] = req_data.vel_a_z;
   assign vb[0] = req_data.vel_b_x;
   assign vb[1] = req_data.vel_b_y;
   assign vb[2] = req_data.vel_b_z;

   always_comb begin
      st1_in.ok = 1'b1;
      for (int i = 0; i < 3; i++) begin
         dfull[i] = 34'(pb[i]) - 34'(pa[i]) + 34'(off_ff[i]);
         dvel[i]  = 33'(vb[i]) - 33'(va[i]);
         if (dfull[i] > dci_pkg::D_LIMIT || dfull[i] < -dci_pkg::D_LIMIT) begin
            st1_in.ok = 1'b0;
         end
         st1_in.d[i]  = dfull[i][26:0];
         st1_in.dv[i] = dvel[i];
         st1_in.va[i] = va[i];
         st1_in.vb[i] = vb[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st1_ff <= st1_in;
      end
   end

   // ---------------------------------------------------------------- stage 2: products
   logic signed [26:0] ds [3];
   logic signed [32:0] dvs [3];
   logic signed [53:0] sqp [3];
   logic signed [59:0] dpp [3];
   st2_type            st2_in;
   st2_type            st2_ff;

   always_comb begin
      st2_in.ok = st1_ff.ok;
      for (int i = 0; i < 3; i++) begin
         ds[i]  = st1_ff.d[i];
         dvs[i] = st1_ff.dv[i];
         sqp[i] = ds[i] * ds[i];
         dpp[i] = dvs[i] * ds[i];
         st2_in.d[i]  = st1_ff.d[i];
         st2_in.sq[i] = sqp[i][52:0];
         st2_in.dp[i] = dpp[i];
         st2_in.va[i] = st1_ff.va[i];
         st2_in.vb[i] = st1_ff.vb[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st2_ff <= st2_in;
      end
   end

   // ---------------------------------------------------------------- stage 3: sums
   st3_type            st3_in;
   st3_type            st3_ff;
   logic signed [26:0] dsg [3];
   logic signed [26:0] dabs [3];

   always_comb begin
      st3_in.sumsq = 55'(st2_ff.sq[0]) + 55'(st2_ff.sq[1]) + 55'(st2_ff.sq[2]);
      st3_in.dot   = 62'($signed(st2_ff.dp[0])) + 62'($signed(st2_ff.dp[1]))
                   + 62'($signed(st2_ff.dp[2]));
      st3_in.c.ok      = st2_ff.ok && (total_ff != '0);
      st3_in.c.gap_len = '0;
      for (int i = 0; i < 3; i++) begin
         dsg[i]  = st2_ff.d[i];
         dabs[i] = dsg[i][26] ? -dsg[i] : dsg[i];
         st3_in.c.dneg[i] = dsg[i][26];
         st3_in.c.dmag[i] = dabs[i][25:0];
         st3_in.c.va[i]   = st2_ff.va[i];
         st3_in.c.vb[i]   = st2_ff.vb[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st3_ff <= st3_in;
      end
   end

   // ---------------------------------------------------------------- square root chain
   dci_pkg::sqrt_lane_type sq_lane [dci_pkg::SQ_STEPS+1];
   sq_side_type            sq_side_in;
   sq_side_type            sq_side_ff [dci_pkg::SQ_STEPS];
   logic signed [61:0]     dot_s;
   logic signed [61:0]     dot_abs;

   assign sq_lane[0] = '{rem: '0, rad: st3_ff.sumsq[dci_pkg::RAD_W-1:0], root: '0};

   // guards on the length run beside the first root digit
   always_comb begin
      dot_s   = st3_ff.dot;
      dot_abs = dot_s[61] ? -dot_s : dot_s;
      sq_side_in.c       = st3_ff.c;
      sq_side_in.c.ok    = st3_ff.c.ok && (st3_ff.sumsq != '0)
                           && (st3_ff.sumsq <= dci_pkg::LIMIT_SQ);
      sq_side_in.dot_neg = dot_s[61];
      sq_side_in.dot_mag = dot_abs[59:0];
   end

   for (genvar k = 0; k < dci_pkg::SQ_STEPS; k++) begin : g_sq
      dci_sqrt_cell u_cell (
         .clock  (clock),
         .en     (en),
         .lane_i (sq_lane[k]),
         .lane_o (sq_lane[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_side_ff[0] <= sq_side_in;
         for (int k = 1; k < dci_pkg::SQ_STEPS; k++) begin
            sq_side_ff[k] <= sq_side_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- divider chain A
   // lane 0: |dot| / gap_len, lanes 1 and 2: inverse mass shares in Q1.30
   dci_pkg::div_lane_type a_lane [dci_pkg::DIV_STEPS+1][dci_pkg::DIV_LANES_A];
   dci_pkg::div_lane_type a_entry [dci_pkg::DIV_LANES_A];
   a_side_type            a_side_in;
   a_side_type            a_side_ff [dci_pkg::DIV_STEPS];
   a_side_type            a_side_div5;
   sq_side_type           sq_last;
   logic [25:0]           gap_len;
   logic signed [26:0]    bias_diff;
   logic signed [26:0]    bias_abs;
   logic [57:0]           bias_prod;

   assign sq_last = sq_side_ff[dci_pkg::SQ_STEPS-1];
   assign gap_len = sq_lane[dci_pkg::SQ_STEPS].root;

   always_comb begin
      a_entry[0].rem = {7'b0, sq_last.dot_mag[59:34]};
      a_entry[0].num = {sq_last.dot_mag[33:0], 30'b0};
      a_entry[0].quo = '0;
      a_entry[0].den = {7'b0, gap_len};
      a_entry[1].rem = {5'b0, inv_a_ff[31:4]};
      a_entry[1].num = {inv_a_ff[3:0], 60'b0};
      a_entry[1].quo = '0;
      a_entry[1].den = total_ff;
      a_entry[2].rem = {5'b0, inv_b_ff[31:4]};
      a_entry[2].num = {inv_b_ff[3:0], 60'b0};
      a_entry[2].quo = '0;
      a_entry[2].den = total_ff;

      bias_diff = $signed({1'b0, gap_len}) - $signed({1'b0, target_ff});
      bias_abs  = bias_diff[26] ? -bias_diff : bias_diff;
      a_side_in.c         = sq_last.c;
      a_side_in.c.gap_len = gap_len;
      a_side_in.dot_neg   = sq_last.dot_neg;
      a_side_in.bias_neg  = bias_diff[26];
      a_side_in.bias      = bias_abs[25:0];
   end

   for (genvar j = 0; j < dci_pkg::DIV_LANES_A; j++) begin : g_a_entry
      assign a_lane[0][j] = a_entry[j];
   end

   for (genvar k = 0; k < dci_pkg::DIV_STEPS; k++) begin : g_a
      for (genvar j = 0; j < dci_pkg::DIV_LANES_A; j++) begin : g_lane
         dci_div_cell u_cell (
            .clock  (clock),
            .en     (en),
            .lane_i (a_lane[k][j]),
            .lane_o (a_lane[k+1][j])
         );
      end
   end

   // bias = |gap_len - target| / 5, by reciprocal in the second side stage
   assign bias_prod = 58'(a_side_ff[0].bias) * 58'(dci_pkg::RECIP5);

   always_comb begin
      a_side_div5      = a_side_ff[0];
      a_side_div5.bias = 26'(bias_prod[57:dci_pkg::RECIP5_SHIFT]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_side_ff[0] <= a_side_in;
         a_side_ff[1] <= a_side_div5;
         for (int k = 2; k < dci_pkg::DIV_STEPS; k++) begin
            a_side_ff[k] <= a_side_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- stages 5..8
   a_side_type         a_last;
   logic signed [35:0] vrel_s;
   logic signed [35:0] bias_s;
   logic signed [35:0] s_abs;
   logic [64:0]        ka_prod;
   logic [64:0]        kb_prod;
   st5_type            st5_in;
   st5_type            st5_ff;
   st6_type            st6_in;
   st6_type            st6_ff;
   st7_type            st7_in;
   st7_type            st7_ff;
   st8_type            st8_in;
   st8_type            st8_ff;

   assign a_last = a_side_ff[dci_pkg::DIV_STEPS-1];

   always_comb begin
      vrel_s = a_last.dot_neg ? -$signed({2'b0, a_lane[dci_pkg::DIV_STEPS][0].quo})
                              : $signed({2'b0, a_lane[dci_pkg::DIV_STEPS][0].quo});
      bias_s = a_last.bias_neg ? -$signed({10'b0, a_last.bias})
                               : $signed({10'b0, a_last.bias});
      st5_in.c  = a_last.c;
      st5_in.s  = vrel_s + bias_s;
      st5_in.ra = a_lane[dci_pkg::DIV_STEPS][1].quo[30:0];
      st5_in.rb = a_lane[dci_pkg::DIV_STEPS][2].quo[30:0];
   end

   always_comb begin
      s_abs = st5_ff.s[35] ? -$signed(st5_ff.s) : $signed(st5_ff.s);
      st6_in.c    = st5_ff.c;
      st6_in.sneg = st5_ff.s[35];
      st6_in.smag = s_abs[33:0];
      st6_in.ra   = st5_ff.ra;
      st6_in.rb   = st5_ff.rb;
   end

   always_comb begin
      ka_prod = 65'(st6_ff.smag) * 65'(st6_ff.ra);
      kb_prod = 65'(st6_ff.smag) * 65'(st6_ff.rb);
      st7_in.c    = st6_ff.c;
      st7_in.sneg = st6_ff.sneg;
      st7_in.ka   = ka_prod[63:30];
      st7_in.kb   = kb_prod[63:30];
   end

   // impulse times gap per axis; sign of each is sign(s) ^ sign(d)
   always_comb begin
      st8_in.c = st7_ff.c;
      for (int i = 0; i < 3; i++) begin
         st8_in.prod[i]   = 60'(st7_ff.ka) * 60'(st7_ff.c.dmag[i]);
         st8_in.prod[i+3] = 60'(st7_ff.kb) * 60'(st7_ff.c.dmag[i]);
         st8_in.neg[i]    = st7_ff.sneg ^ st7_ff.c.dneg[i];
         st8_in.neg[i+3]  = st7_ff.sneg ^ st7_ff.c.dneg[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st5_ff <= st5_in;
         st6_ff <= st6_in;
         st7_ff <= st7_in;
         st8_ff <= st8_in;
      end
   end

   // ---------------------------------------------------------------- divider chain B
   // lanes 0..2: body A axes, lanes 3..5: body B axes, each |k * d| / gap_len
   dci_pkg::div_lane_type b_lane [dci_pkg::DIV_STEPS+1][dci_pkg::DIV_LANES_B];
   dci_pkg::div_lane_type b_entry [dci_pkg::DIV_LANES_B];
   b_side_type            b_side_ff [dci_pkg::DIV_STEPS];

   always_comb begin
      for (int j = 0; j < dci_pkg::DIV_LANES_B; j++) begin
         b_entry[j].rem = {7'b0, st8_ff.prod[j][59:34]};
         b_entry[j].num = {st8_ff.prod[j][33:0], 30'b0};
         b_entry[j].quo = '0;
         b_entry[j].den = {7'b0, st8_ff.c.gap_len};
      end
   end

   for (genvar j = 0; j < dci_pkg::DIV_LANES_B; j++) begin : g_b_entry
      assign b_lane[0][j] = b_entry[j];
   end

   for (genvar k = 0; k < dci_pkg::DIV_STEPS; k++) begin : g_b
      for (genvar j = 0; j < dci_pkg::DIV_LANES_B; j++) begin : g_lane
         dci_div_cell u_cell (
            .clock  (clock),
            .en     (en),
            .lane_i (b_lane[k][j]),
            .lane_o (b_lane[k+1][j])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_side_ff[0] <= '{c: st8_ff.c, neg: st8_ff.neg};
         for (int k = 1; k < dci_pkg::DIV_STEPS; k++) begin
            b_side_ff[k] <= b_side_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- velocity update
   b_side_type         b_last;
   logic signed [35:0] dq [6];
   logic signed [35:0] nv [6];
   logic signed [31:0] vout [6];

   assign b_last = b_side_ff[dci_pkg::DIV_STEPS-1];

   always_comb begin
      for (int j = 0; j < dci_pkg::DIV_LANES_B; j++) begin
         dq[j] = b_last.neg[j] ? -$signed({2'b0, b_lane[dci_pkg::DIV_STEPS][j].quo})
                               : $signed({2'b0, b_lane[dci_pkg::DIV_STEPS][j].quo});
      end
      for (int i = 0; i < 3; i++) begin
         nv[i]   = 36'($signed(b_last.c.va[i])) + dq[i];
         nv[i+3] = 36'($signed(b_last.c.vb[i])) - dq[i+3];
         vout[i]   = b_last.c.ok ? dci_pkg::sat32(nv[i])   : $signed(b_last.c.va[i]);
         vout[i+3] = b_last.c.ok ? dci_pkg::sat32(nv[i+3]) : $signed(b_last.c.vb[i]);
      end
      tail_rsp.new_vel_a_x = vout[0];
      tail_rsp.new_vel_a_y = vout[1];
      tail_rsp.new_vel_a_z = vout[2];
      tail_rsp.new_vel_b_x = vout[3];
      tail_rsp.new_vel_b_y = vout[4];
      tail_rsp.new_vel_b_z = vout[5];
      tail_rsp.applied     = b_last.c.ok;
   end

   // ---------------------------------------------------------------- output and skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (take) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (tail_vld) begin
         if (out_vld_ff && !take) begin
            skid_vld_ff <= 1'b1;
         end else begin
            out_vld_ff <= 1'b1;
         end
      end else if (take) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (tail_vld) begin
         if (out_vld_ff && !take) begin
            skid_ff <= tail_rsp;
         end else begin
            out_ff <= tail_rsp;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/dci_sqrt_cell.sv]
// One digit step of the pipelined integer square root.
`default_nettype none

module dci_sqrt_cell (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire dci_pkg::sqrt_lane_type lane_i,
   output dci_pkg::sqrt_lane_type      lane_o
);

   dci_pkg::sqrt_lane_type lane_ff;
   dci_pkg::sqrt_lane_type lane_in;

   logic [dci_pkg::SQREM_W+1:0] trial;
   logic [dci_pkg::SQREM_W+1:0] part;
   logic [dci_pkg::SQREM_W+1:0] diff;
   logic                        ge;

   always_comb begin
      part  = {lane_i.rem, lane_i.rad[dci_pkg::RAD_W-1 -: 2]};
      trial = {1'b0, lane_i.root, 2'b01};
      ge    = (part >= trial);
      diff  = part - trial;
      lane_in.rem  = ge ? diff[dci_pkg::SQREM_W-1:0] : part[dci_pkg::SQREM_W-1:0];
      lane_in.rad  = {lane_i.rad[dci_pkg::RAD_W-3:0], 2'b00};
      lane_in.root = {lane_i.root[dci_pkg::ROOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;

endmodule

`default_nettype wire

[rtl/core/dci_div_cell.sv]
// One restoring division step for one divider lane.
`default_nettype none

module dci_div_cell (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire dci_pkg::div_lane_type lane_i,
   output dci_pkg::div_lane_type      lane_o
);

   dci_pkg::div_lane_type lane_ff;
   dci_pkg::div_lane_type lane_in;

   logic [dci_pkg::REM_W:0] part;
   logic [dci_pkg::REM_W:0] diff;
   logic                    ge;

   always_comb begin
      part = {lane_i.rem, lane_i.num[dci_pkg::NUM_W-1]};
      ge   = (part >= {1'b0, lane_i.den});
      diff = part - {1'b0, lane_i.den};
      lane_in.rem = ge ? diff[dci_pkg::REM_W-1:0] : part[dci_pkg::REM_W-1:0];
      lane_in.num = {lane_i.num[dci_pkg::NUM_W-2:0], 1'b0};
      lane_in.quo = {lane_i.quo[dci_pkg::QUO_W-2:0], ge};
      lane_in.den = lane_i.den;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;

endmodule

`default_nettype wire

[tb/dci_checker.sv]
// Checker: watches the req/rsp/csr channels, predicts each result and compares.
module dci_checker
   import dci_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire req_type              req_data,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire rsp_type              rsp_data,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_data,
   output int                        errors,
   output int                        outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint GAP_MAX   = 64'sd65536000;
   localparam longint GAP_SQMAX = 64'sd65536000 * 64'sd65536000;

   logic signed [63:0] off [3];
   logic        [63:0] target_len;
   logic        [63:0] inv_a;
   logic        [63:0] inv_b;
   rsp_type            expected_vel [$];
   int                 n_checked;

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [63:0] mass_share(input logic signed [63:0] s,
                                                     input logic [63:0] inv,
                                                     input logic [63:0] total);
      logic [63:0] ratio;
      logic [63:0] mag;
      logic [63:0] k;
      ratio = (inv << 30) / total;
      mag   = (s < 0) ? -s : s;
      k     = (mag * ratio) >> 30;
      return (s < 0) ? -$signed(k) : $signed(k);
   endfunction

   function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic rsp_type predict_velocity(input req_type r);
      logic signed [63:0] pa [3];
      logic signed [63:0] pb [3];
      logic signed [63:0] va [3];
      logic signed [63:0] vb [3];
      logic signed [63:0] na [3];
      logic signed [63:0] nb [3];
      logic signed [63:0] d  [3];
      logic signed [63:0] gap_len, dot, s, ka, kb;
      logic        [63:0] sumsq, total;
      logic               ok;
      rsp_type            o;
      pa = '{r.pos_a_x, r.pos_a_y, r.pos_a_z};
      pb = '{r.pos_b_x, r.pos_b_y, r.pos_b_z};
      va = '{r.vel_a_x, r.vel_a_y, r.vel_a_z};
      vb = '{r.vel_b_x, r.vel_b_y, r.vel_b_z};
      total = inv_a + inv_b;
      ok    = 1'b1;
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
         d[i]  = pb[i] - pa[i] + off[i];
         na[i] = va[i];
         nb[i] = vb[i];
         if (d[i] > GAP_MAX || d[i] < -GAP_MAX) ok = 1'b0;
      end
      if (ok) begin
         for (int i = 0; i < 3; i++) sumsq += d[i] * d[i];
         if (sumsq == 0 || sumsq > GAP_SQMAX || total == 0) ok = 1'b0;
      end
      if (ok) begin
         gap_len = $signed(floor_sqrt(sumsq));
         dot     = 0;
         for (int i = 0; i < 3; i++) dot += (vb[i] - va[i]) * d[i];
         s  = dot / gap_len + (gap_len - $signed(target_len)) / 5;
         ka = mass_share(s, inv_a, total);
         kb = mass_share(s, inv_b, total);
         for (int i = 0; i < 3; i++) begin
            na[i] = va[i] + (ka * d[i]) / gap_len;
            nb[i] = vb[i] - (kb * d[i]) / gap_len;
         end
      end
      o.new_vel_a_x = clamp32(na[0]);
      o.new_vel_a_y = clamp32(na[1]);
      o.new_vel_a_z = clamp32(na[2]);
      o.new_vel_b_x = clamp32(nb[0]);
      o.new_vel_b_y = clamp32(nb[1]);
      o.new_vel_b_z = clamp32(nb[2]);
      o.applied     = ok;
      return o;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
      $display("mismatch rsp %0d %s: got %h exp %h", n_checked, what, got, exp);
      errors++;
   endtask

   initial begin
      errors      = 0;
      outstanding = 0;
      n_checked   = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         off        = '{0, 0, 0};
         target_len = 0;
         inv_a      = 0;
         inv_b      = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_OFFSET_X:   off[0]     = $signed(csr_data);
               CSR_OFFSET_Y:   off[1]     = $signed(csr_data);
               CSR_OFFSET_Z:   off[2]     = $signed(csr_data);
               CSR_TARGET:     target_len = csr_data[25:0];
               CSR_INV_MASS_A: inv_a      = csr_data;
               CSR_INV_MASS_B: inv_b      = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_vel.push_back(predict_velocity(req_data));
         if (rsp_valid && !rsp_stall) begin
            rsp_type e;
            if (expected_vel.size() == 0) begin
               $display("mismatch: unexpected rsp transfer %0d", n_checked);
               errors++;
            end else begin
               e = expected_vel.pop_front();
               if (rsp_data.new_vel_a_x !== e.new_vel_a_x)
                  report("new_vel_a_x", rsp_data.new_vel_a_x, e.new_vel_a_x);
               if (rsp_data.new_vel_a_y !== e.new_vel_a_y)
                  report("new_vel_a_y", rsp_data.new_vel_a_y, e.new_vel_a_y);
               if (rsp_data.new_vel_a_z !== e.new_vel_a_z)
                  report("new_vel_a_z", rsp_data.new_vel_a_z, e.new_vel_a_z);
               if (rsp_data.new_vel_b_x !== e.new_vel_b_x)
                  report("new_vel_b_x", rsp_data.new_vel_b_x, e.new_vel_b_x);
               if (rsp_data.new_vel_b_y !== e.new_vel_b_y)
                  report("new_vel_b_y", rsp_data.new_vel_b_y, e.new_vel_b_y);
               if (rsp_data.new_vel_b_z !== e.new_vel_b_z)
                  report("new_vel_b_z", rsp_data.new_vel_b_z, e.new_vel_b_z);
               if (rsp_data.applied !== e.applied)
                  report("applied", rsp_data.applied, e.applied);
            end
            n_checked++;
         end
      end
      outstanding = expected_vel.size();
   end
endmodule

[tb/testbench.sv]
// Testbench top: clock, reset, stimulus and verdict for the distance constraint block.
module testbench;
   import dci_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY     = 102;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int HOLD_CYCLES = 400;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;
   int                   errors;
   int                   outstanding;
   int                   cycles = 0;

   // stimulus knobs shared between processes
   bit                   calm = 1'b0;     // no idling on either side
   bit                   hold_on = 1'b0;  // receiver blocks all rsp transfers
   event                 hold_kick;
   logic signed [63:0]   cur_off [3] = '{0, 0, 0};

   always #10 clock = ~clock;

   distance_constraint_impulse u_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   dci_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .errors, .outstanding
   );

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // long receiver hold-off, counted here so the sender keeps pushing meanwhile
   initial begin
      forever begin
         @(hold_kick);
         hold_on = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_on = 1'b0;
      end
   end

   // receiver: stalls about 9% of cycles unless in a calm stretch
   always @(posedge clock) begin
      rsp_stall <= hold_on || (!calm && $urandom_range(99) < 9);
   end

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx <= CSR_OFFSET_Z) cur_off[idx] = $signed(value);
   endtask

   // pause until everything in flight has drained
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic load_setting(input logic [31:0] ox, input logic [31:0] oy,
                               input logic [31:0] oz, input logic [31:0] tgt,
                               input logic [31:0] ia, input logic [31:0] ib);
      drain();
      write_csr(CSR_OFFSET_X, ox);
      write_csr(CSR_OFFSET_Y, oy);
      write_csr(CSR_OFFSET_Z, oz);
      write_csr(CSR_TARGET, tgt);
      write_csr(CSR_INV_MASS_A, ia);
      write_csr(CSR_INV_MASS_B, ib);
   endtask

   // one req transfer, with an occasional idle gap first
   task automatic send(input req_type item);
      if (!calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // item whose anchor gap is (dx, dy, dz) under the current offsets
   function automatic req_type gap_item(input longint dx, input longint dy, input longint dz,
                                        input logic [31:0] va, input logic [31:0] vb);
      req_type r;
      r = {$urandom, $urandom, $urandom, 96'b0, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
      r.pos_b_x = r.pos_a_x + dx - cur_off[0];
      r.pos_b_y = r.pos_a_y + dy - cur_off[1];
      r.pos_b_z = r.pos_a_z + dz - cur_off[2];
      r.vel_a_x = va;
      r.vel_b_x = vb;
      return r;
   endfunction

   function automatic longint rand_gap(input int reach);
      longint m;
      m = $urandom_range(reach);
      return $urandom_range(1) ? -m : m;
   endfunction

   // random item: mostly well-formed gaps with assorted velocity scales, some noise
   function automatic req_type random_item;
      req_type r;
      int      sel;
      int      reach;
      sel = $urandom_range(99);
      if (sel < 12) begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
         reach = (sel < 30) ? 65536000 : (sel < 60) ? 4000000 : 300000;
         r = gap_item(rand_gap(reach), rand_gap(reach), rand_gap(reach), 0, 0);
         if ($urandom_range(3) == 0) begin
            {r.vel_a_x, r.vel_a_y, r.vel_a_z} = {$urandom, $urandom, $urandom};
            {r.vel_b_x, r.vel_b_y, r.vel_b_z} = {$urandom, $urandom, $urandom};
         end else begin
            r.vel_a_x = $signed(20'($urandom)); r.vel_a_y = $signed(20'($urandom));
            r.vel_a_z = $signed(20'($urandom)); r.vel_b_x = $signed(20'($urandom));
            r.vel_b_y = $signed(20'($urandom)); r.vel_b_z = $signed(20'($urandom));
         end
      end
      return r;
   endfunction

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         calm = (i >= count / 3 && i < count / 3 + 60);
         if (i == count / 2) -> hold_kick;
         if (i == 3 * count / 4) drain();
         send(random_item());
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset both bodies are static: everything passes through
      send(gap_item(65536, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
      send(random_item());

      load_setting(0, 0, 0, 32'd65536, 32'd65536, 32'd65536);
      send(gap_item(0, 0, 0, 100, 200));                     // zero gap
      send(gap_item(1, 0, 0, 0, 0));                         // smallest gap
      send(gap_item(65536000, 0, 0, 65536, -65536));        // on the limit
      send(gap_item(-65536000, 0, 0, 65536, 0));
      send(gap_item(65536001, 0, 0, 65536, 0));              // one axis too long
      send(gap_item(0, -65536001, 0, 65536, 0));
      send(gap_item(50000000, 50000000, 0, 0, 0));           // length over the limit
      send(gap_item(37837060, 37837060, 37837060, 7, 9));    // length just under the limit
      send(gap_item(1, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000)); // saturating swing
      send(gap_item(3, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
      send(gap_item(65536, 65536, 65536, 0, 0));
      send(gap_item(-131072, 65536, -3, 1000, -1000));
      random_phase(250);

      // extremes of every register
      load_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'd65536000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(gap_item(0, 0, 0, 5, 5));
      send(gap_item(-65536000, -65536000, 0, 1, 2));
      send(gap_item(2, -2, 1, 32'h7FFF_FFFF, 32'h8000_0000));
      random_phase(250);

      // body A static
      load_setting(32'h0001_0000, 32'hFFFF_8000, 0, 0, 0, 32'h0002_0000);
      send(gap_item(655360, 0, 0, 65536, -65536));
      random_phase(270);

      // body B static, mixed offsets
      load_setting(32'h8000_0000, 32'h0000_1234, 32'h8000_0000,
                   32'd3276800, 32'h0000_8000, 0);
      send(gap_item(0, 655360, 0, -65536, 65536));
      random_phase(270);

      // both static again
      load_setting(32'h1234_5678, 32'hEDCB_A987, 32'h0000_0001, 32'd1, 0, 0);
      random_phase(120);

      // random settings
      for (int k = 0; k < 3; k++) begin
         load_setting($urandom_range(1) ? $urandom : $signed(24'($urandom)),
                      $urandom_range(1) ? $urandom : $signed(24'($urandom)),
                      $urandom_range(1) ? $urandom : $signed(24'($urandom)),
                      $urandom_range(65536000), $urandom, $urandom);
         random_phase(150);
      end

      drain();
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
